// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros shared by the ranger controller rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent assertion on the house clock and reset
`define ASSERT(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/urc_pkg.sv -----
// ----------------------------------------------------------------------------
// urc_pkg
// types and constants of the ultrasonic ranger controller
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int unsigned TICKS_W      = 17;
  localparam int unsigned INTERVAL_W   = 24;
  localparam int unsigned DIST_W       = 16;
  localparam int unsigned START_TO_W   = 16;
  localparam int unsigned FRAME_NUM_W  = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 24;

  typedef logic [TICKS_W-1:0]     ticks_t;
  typedef logic [INTERVAL_W-1:0]  interval_t;
  typedef logic [DIST_W-1:0]      dist_t;
  typedef logic [START_TO_W-1:0]  start_to_t;
  typedef logic [FRAME_NUM_W-1:0] frame_num_t;

  // trigger timing in ticks
  localparam int unsigned TRIG_LOW_TICKS  = 5;
  localparam int unsigned TRIG_HIGH_TICKS = 10;
  localparam ticks_t TRIG_LOW_LAST  = ticks_t'(TRIG_LOW_TICKS - 1);
  localparam ticks_t TRIG_HIGH_LAST = ticks_t'(TRIG_HIGH_TICKS - 1);

  localparam interval_t INTERVAL_MAX = '1;

  // floor(t * 5 / 29) == (t * DIST_MUL) >> DIST_SHIFT, exact for t < 2**17
  localparam int unsigned DIST_MUL_W = 23;
  localparam int unsigned DIST_SHIFT = 25;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = 23'd5785250;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_START_TIMEOUT = 2'd1,
    ST_PULSE_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_ENABLE    = 3'd0,
    CFG_SCAN_INTERVAL = 3'd1,
    CFG_MAX_DISTANCE  = 3'd2,
    CFG_START_TIMEOUT = 3'd3,
    CFG_PULSE_TIMEOUT = 3'd4
  } cfg_idx_e;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TLOW  = 6'b000010,
    PH_THIGH = 6'b000100,
    PH_WAIT  = 6'b001000,
    PH_PULSE = 6'b010000,
    PH_HOLD  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic      run_enable;
    interval_t scan_interval_us;
    dist_t     max_range_mm;
    start_to_t echo_start_timeout_us;
    ticks_t    pulse_timeout_us;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    run_enable:            1'b0,
    scan_interval_us:      24'd100000,
    max_range_mm:          16'd4000,
    echo_start_timeout_us: 16'd100,
    pulse_timeout_us:      17'd100000
  };

  typedef struct packed {
    logic       trigger_level;
    logic       frame_done;
    dist_t      range_mm;
    logic       distance_valid;
    status_e    status;
    frame_num_t frame_number;
  } res_t;

endpackage

// ----- rtl/core/urc_in_if.sv -----
// ----------------------------------------------------------------------------
// urc_in_if
// tick channel: one echo sample per beat
// ----------------------------------------------------------------------------
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

// ----- rtl/core/urc_out_if.sv -----
// ----------------------------------------------------------------------------
// urc_out_if
// result channel: trigger drive and measurement result per beat
// ----------------------------------------------------------------------------
interface urc_out_if;
  import urc_pkg::*;

  logic       valid;
  logic       ready;
  logic       trigger_level;
  logic       frame_done;
  dist_t      range_mm;
  logic       distance_valid;
  status_e    status;
  frame_num_t frame_number;

  modport source (
    output valid, output trigger_level, output frame_done, output range_mm,
    output distance_valid, output status, output frame_number, input ready
  );
  modport sink (
    input valid, input trigger_level, input frame_done, input range_mm,
    input distance_valid, input status, input frame_number, output ready
  );
endinterface

// ----- rtl/core/urc_cfg.sv -----
// ----------------------------------------------------------------------------
// urc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module urc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0] wdata_i,
  output urc_pkg::cfg_t                  cfg_o
);
  import urc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_RUN_ENABLE:    cfg_d.run_enable            = wdata_i[0];
        CFG_SCAN_INTERVAL: cfg_d.scan_interval_us      = wdata_i[INTERVAL_W-1:0];
        CFG_MAX_DISTANCE:  cfg_d.max_range_mm          = wdata_i[DIST_W-1:0];
        CFG_START_TIMEOUT: cfg_d.echo_start_timeout_us = wdata_i[START_TO_W-1:0];
        CFG_PULSE_TIMEOUT: cfg_d.pulse_timeout_us      = wdata_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/urc_dist.sv -----
// ----------------------------------------------------------------------------
// urc_dist
// echo ticks to millimetres, with range check against the maximum
// ----------------------------------------------------------------------------
module urc_dist (
  input  urc_pkg::ticks_t ticks_i,
  input  urc_pkg::dist_t  max_i,
  output urc_pkg::dist_t  dist_o,
  output logic            valid_o
);
  import urc_pkg::*;

  localparam int unsigned PROD_W = TICKS_W + DIST_MUL_W;

  logic [PROD_W-1:0] prod;
  dist_t             raw;
  logic              in_range;

  // reciprocal multiply replaces the divide by 5.8
  assign prod     = PROD_W'(ticks_i) * PROD_W'(DIST_MUL);
  assign raw      = DIST_W'(prod[PROD_W-1:DIST_SHIFT]);
  assign in_range = (raw <= max_i);
  assign dist_o   = in_range ? raw : '0;
  assign valid_o  = in_range && (raw != '0);

endmodule

// ----- rtl/core/urc_seq.sv -----
// ----------------------------------------------------------------------------
// urc_seq
// measurement sequencer: phase, tick counters and per-tick result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urc_seq #(
  parameter int unsigned FRAME_COUNT_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           echo_i,
  input  urc_pkg::cfg_t  cfg_i,
  output urc_pkg::res_t  res_o
);
  import urc_pkg::*;

  localparam int unsigned FN_W = (FRAME_COUNT_BITS < FRAME_NUM_W) ?
                                 FRAME_COUNT_BITS : FRAME_NUM_W;

  phase_e                      phase_q, phase_d;
  ticks_t                      ticks_q, ticks_d;
  interval_t                   interval_q, interval_d;
  logic [FRAME_COUNT_BITS-1:0] frame_q, frame_d;

  dist_t calc_mm;
  logic  dist_valid;
  logic  err_start, err_pulse, done_ok;
  res_t  res;

  urc_dist u_dist (
    .ticks_i (ticks_q),
    .max_i   (cfg_i.max_range_mm),
    .dist_o  (calc_mm),
    .valid_o (dist_valid)
  );

  always_comb begin
    phase_d    = phase_q;
    ticks_d    = ticks_q;
    interval_d = interval_q;
    frame_d    = frame_q;
    err_start  = 1'b0;
    err_pulse  = 1'b0;
    done_ok    = 1'b0;
    res        = '0;

    if (!(phase_q inside {PH_IDLE, PH_TLOW, PH_THIGH, PH_WAIT, PH_PULSE, PH_HOLD})) begin
      phase_d = PH_IDLE;
    end
    if (phase_d == PH_HOLD && !cfg_i.run_enable) begin
      phase_d = PH_IDLE;
    end

    // start of a new measurement
    if (cfg_i.run_enable && (phase_d == PH_IDLE ||
        (phase_d == PH_HOLD && interval_d >= cfg_i.scan_interval_us))) begin
      phase_d    = PH_TLOW;
      ticks_d    = '0;
      interval_d = '0;
    end

    if (phase_d != PH_IDLE && interval_d != INTERVAL_MAX) begin
      interval_d = interval_d + 1'b1;
    end

    case (phase_d)
      PH_TLOW: begin
        if (ticks_d >= TRIG_LOW_LAST) begin
          phase_d = PH_THIGH;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_d + 1'b1;
        end
      end
      PH_THIGH: begin
        res.trigger_level = 1'b1;
        if (ticks_d >= TRIG_HIGH_LAST) begin
          phase_d = PH_WAIT;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_d + 1'b1;
        end
      end
      PH_WAIT: begin
        if (echo_i) begin
          phase_d = PH_PULSE;
          ticks_d = '0;
        end else if (ticks_d >= TICKS_W'(cfg_i.echo_start_timeout_us)) begin
          err_start = 1'b1;
        end else begin
          ticks_d = ticks_d + 1'b1;
        end
      end
      default: ;
    endcase

    // a pulse entered this tick is counted at once
    if (phase_d == PH_PULSE) begin
      if (echo_i) begin
        if (ticks_d >= cfg_i.pulse_timeout_us) begin
          err_pulse = 1'b1;
        end else begin
          ticks_d = ticks_d + 1'b1;
        end
      end else begin
        done_ok = 1'b1;
      end
    end

    if (err_start || err_pulse || done_ok) begin
      res.frame_done     = 1'b1;
      res.range_mm       = done_ok ? calc_mm : '0;
      res.distance_valid = done_ok && dist_valid;
      res.status         = err_start ? ST_START_TIMEOUT :
                           err_pulse ? ST_PULSE_TIMEOUT : ST_OK;
      res.frame_number   = frame_num_t'(frame_q[FN_W-1:0]);
      frame_d            = frame_q + 1'b1;
      phase_d            = PH_HOLD;
      ticks_d            = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      ticks_q    <= '0;
      interval_q <= '0;
      frame_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      ticks_q    <= ticks_d;
      interval_q <= interval_d;
      frame_q    <= frame_d;
    end
  end

  assign res_o = res;

  `ASSERT(seq_done_holds, step_i && res.frame_done |=> phase_q == PH_HOLD,
          "result beat not followed by hold phase")
  `ASSERT(seq_error_zero_dist, res.status != ST_OK |-> res.range_mm == '0 && !res.distance_valid,
          "timeout result carries a distance")

endmodule

// ----- rtl/core/urc_skid.sv -----
// ----------------------------------------------------------------------------
// urc_skid
// result register with skid entry between sequencer and result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urc_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  urc_pkg::res_t res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output urc_pkg::res_t res_o
);
  import urc_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic in_fire, out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  `ASSERT(skid_needs_out, skid_valid_q |-> out_valid_q,
          "skid entry held with empty output register")
  `ASSERT(skid_catches_stall, in_fire && out_valid_q && !out_ready_i |=> skid_valid_q,
          "beat taken during stall not kept in skid entry")

endmodule

// ----- rtl/core/ultrasonic_ranger_controller.sv -----
// a taken tick beat's result is registered in the output register or the skid entry
// throughput: a tick beat per cycle while skid is empty, via phase and counter update
// a stalled result channel is absorbed by one skid entry; ticks stop when both are full
// reset: asynchronous, active low; sequencer idle, counters zero, registers at defaults
// ----------------------------------------------------------------------------
// ultrasonic_ranger_controller
// echo-time range finder: trigger pulse, echo timing, distance in millimetres
// ----------------------------------------------------------------------------
module ultrasonic_ranger_controller #(
  parameter int unsigned FRAME_COUNT_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  urc_in_if.sink                         in_i,
  urc_out_if.source                      res_o
);
  import urc_pkg::*;

  cfg_t cfg;
  res_t res_seq;   // result of the tick being taken
  res_t res_out;   // registered result on the channel
  logic step;

  // register file, writes land at once and the sequencer sees them next tick
  urc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // a tick advances the sequencer only when its beat is taken
  assign step = in_i.valid && in_i.ready;

  // phase, trigger timing, echo timing and distance for one tick
  urc_seq #(
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .echo_i (in_i.echo_level),
    .cfg_i  (cfg),
    .res_o  (res_seq)
  );

  // result register plus skid entry keeps the tick side moving during stalls
  urc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .res_i       (res_seq),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .res_o       (res_out)
  );

  // fan the registered result out onto the channel fields
  assign res_o.trigger_level  = res_out.trigger_level;
  assign res_o.frame_done     = res_out.frame_done;
  assign res_o.range_mm       = res_out.range_mm;
  assign res_o.distance_valid = res_out.distance_valid;
  assign res_o.status         = res_out.status;
  assign res_o.frame_number   = res_out.frame_number;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// ultrasonic ranger controller: echo sample ticks against a cycle-true model
// of the trigger, echo timing and distance logic, under random flow control
// ----------------------------------------------------------------------------
module testbench;
  import urc_pkg::*;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  // output register plus the skid entry, with margin
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned SEGMENT_TICKS  = 104;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned ECHO_WAIT_CAP  = 12;
  localparam int unsigned ECHO_PULSE_CAP = 80;
  localparam int unsigned NOISE_PCT      = 6;

  // what the feeder does next: a tick beat, a register write or a pacing change
  typedef enum int unsigned {
    ACT_TICK,
    ACT_CFG,
    ACT_DRAIN,
    ACT_MODE,
    ACT_HOLDOFF
  } act_e;

  typedef struct {
    act_e                  kind;
    logic                  echo;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           send_idle;
    int unsigned           recv_stall;
  } act_t;

  // sequencer state of the ranger as seen between ticks
  typedef struct {
    phase_e     phase;
    ticks_t     ticks;
    interval_t  since_start;
    frame_num_t frames;
  } ranger_t;

  localparam ranger_t RANGER_IDLE = '{
    phase: PH_IDLE, ticks: '0, since_start: '0, frames: '0
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  urc_in_if  in_if ();
  urc_out_if res_if ();

  ultrasonic_ranger_controller DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  // script of tick beats and control steps, filled before reset is released
  act_t        echo_script_q[$];
  // results still owed by the block, oldest first
  res_t        due_results_q[$];

  // planning copy runs ahead while the script is built, live copy follows the beats
  cfg_t        plan_cfg;
  cfg_t        live_cfg;
  ranger_t     plan_ranger;
  ranger_t     live_ranger;

  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_req    = 0;
  int unsigned holdoff_ack    = 0;
  int unsigned holdoff_left   = 0;
  logic        tick_taken     = 1'b0;

  // echo waveform planner: lows then highs once the block waits for echo
  logic        echo_planned   = 1'b0;
  int unsigned echo_lows      = 0;
  int unsigned echo_highs     = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic void write_reg(inout cfg_t c, input cfg_idx_e idx,
                                    input logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_RUN_ENABLE:    c.run_enable            = v[0];
      CFG_SCAN_INTERVAL: c.scan_interval_us      = v[INTERVAL_W-1:0];
      CFG_MAX_DISTANCE:  c.max_range_mm          = v[DIST_W-1:0];
      CFG_START_TIMEOUT: c.echo_start_timeout_us = v[START_TO_W-1:0];
      CFG_PULSE_TIMEOUT: c.pulse_timeout_us      = v[TICKS_W-1:0];
      default: ;
    endcase
  endfunction

  // one microsecond tick of the ranger: advances the state, returns the result beat
  function automatic res_t ranger_step(inout ranger_t s, input cfg_t c, input logic echo);
    res_t        r;
    logic        done;
    status_e     st;
    int unsigned d;
    r    = '0;
    done = 1'b0;
    st   = ST_OK;
    d    = 0;

    // disabling lets a running measurement finish, then the block parks
    if (s.phase == PH_HOLD && !c.run_enable) s.phase = PH_IDLE;
    if (c.run_enable && (s.phase == PH_IDLE ||
        (s.phase == PH_HOLD && s.since_start >= c.scan_interval_us))) begin
      s.phase       = PH_TLOW;
      s.ticks       = '0;
      s.since_start = '0;
    end
    // interval counter saturates
    if (s.phase != PH_IDLE && s.since_start != INTERVAL_MAX) s.since_start++;

    case (s.phase)
      PH_TLOW: begin
        s.ticks++;
        if (s.ticks >= TRIG_LOW_TICKS) begin
          s.phase = PH_THIGH;
          s.ticks = '0;
        end
      end
      PH_THIGH: begin
        r.trigger_level = 1'b1;
        s.ticks++;
        if (s.ticks >= TRIG_HIGH_TICKS) begin
          s.phase = PH_WAIT;
          s.ticks = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          s.phase = PH_PULSE;
          s.ticks = '0;
        end else if (s.ticks >= c.echo_start_timeout_us) begin
          done = 1'b1;
          st   = ST_START_TIMEOUT;
        end else begin
          s.ticks++;
        end
      end
      default: ;
    endcase

    // a pulse that starts this tick is counted this tick too
    if (s.phase == PH_PULSE && !done) begin
      if (echo) begin
        if (s.ticks >= c.pulse_timeout_us) begin
          done = 1'b1;
          st   = ST_PULSE_TIMEOUT;
        end else begin
          s.ticks++;
        end
      end else begin
        // count / 5.8 in exact integer form
        d = (int'(s.ticks) * 5) / 29;
        if (d > c.max_range_mm) d = 0;
        done = 1'b1;
      end
    end

    if (done) begin
      r.frame_done     = 1'b1;
      r.range_mm       = dist_t'(d);
      r.distance_valid = (d != 0) && (d <= c.max_range_mm);
      r.status         = st;
      r.frame_number   = s.frames;
      s.frames++;
      s.phase = PH_HOLD;
      s.ticks = '0;
    end
    return r;
  endfunction

  function automatic void add_tick(input logic echo);
    act_t a;
    res_t ignored;
    a = '{kind: ACT_TICK, echo: echo, idx: CFG_RUN_ENABLE, data: '0,
          send_idle: 0, recv_stall: 0};
    echo_script_q.insert(echo_script_q.size(), a);
    ignored = ranger_step(plan_ranger, plan_cfg, echo);
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input int unsigned v);
    act_t a;
    a = '{kind: ACT_CFG, echo: 1'b0, idx: idx, data: CFG_DATA_W'(v), send_idle: 0,
          recv_stall: 0};
    echo_script_q.insert(echo_script_q.size(), a);
    write_reg(plan_cfg, idx, CFG_DATA_W'(v));
  endfunction

  function automatic void add_ctl(input act_e kind, input int unsigned send_idle,
                                  input int unsigned recv_stall);
    act_t a;
    a = '{kind: kind, echo: 1'b0, idx: CFG_RUN_ENABLE, data: '0,
          send_idle: send_idle, recv_stall: recv_stall};
    echo_script_q.insert(echo_script_q.size(), a);
  endfunction

  // tick feeder: one beat at a time, register writes only once the block is drained
  always @(negedge clk) begin : feed_ticks
    act_t                  a;
    logic                  valid_nx;
    logic                  echo_nx;
    logic                  we_nx;
    logic [CFG_IDX_W-1:0]  idx_nx;
    logic [CFG_DATA_W-1:0] data_nx;
    valid_nx = in_if.valid;
    echo_nx  = in_if.echo_level;
    we_nx    = 1'b0;
    idx_nx   = cfg_idx;
    data_nx  = cfg_wdata;
    if (due_results_q.size() == 0) quiet_cycles++;
    else quiet_cycles = 0;

    if (!rst_n) begin
      valid_nx = 1'b0;
    end else if (!in_if.valid || tick_taken) begin
      valid_nx = 1'b0;
      if (echo_script_q.size() != 0) begin
        a = echo_script_q[0];
        case (a.kind)
          ACT_TICK: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              valid_nx = 1'b1;
              echo_nx  = a.echo;
              echo_script_q.delete(0);
            end
          end
          ACT_CFG: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              we_nx   = 1'b1;
              idx_nx  = a.idx;
              data_nx = a.data;
              write_reg(live_cfg, a.idx, a.data);
              echo_script_q.delete(0);
            end
          end
          ACT_DRAIN: begin
            if (quiet_cycles >= SETTLE_CYCLES) echo_script_q.delete(0);
          end
          ACT_MODE: begin
            send_idle_pct  <= a.send_idle;
            recv_stall_pct <= a.recv_stall;
            echo_script_q.delete(0);
          end
          ACT_HOLDOFF: begin
            holdoff_req <= holdoff_req + 1;
            echo_script_q.delete(0);
          end
          default: echo_script_q.delete(0);
        endcase
      end
    end

    in_if.valid      <= valid_nx;
    in_if.echo_level <= echo_nx;
    cfg_we           <= we_nx;
    cfg_idx          <= idx_nx;
    cfg_wdata        <= data_nx;
  end

  // result side pacing, with a long hold-off on request so the skid fills up
  always @(negedge clk) begin : pace_results
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (holdoff_ack != holdoff_req) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      res_if.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // predict on every tick beat taken, check every result beat against the oldest
  always @(posedge clk) begin : check_results
    res_t seen;
    res_t want;
    if (!rst_n) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        due_results_q.insert(due_results_q.size(),
                             ranger_step(live_ranger, live_cfg, in_if.echo_level));
      if (res_if.valid && res_if.ready) begin
        seen = '{trigger_level: res_if.trigger_level, frame_done: res_if.frame_done,
                 range_mm: res_if.range_mm, distance_valid: res_if.distance_valid,
                 status: res_if.status, frame_number: res_if.frame_number};
        if (due_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("ranger: unexpected result beat trig %b done %b dist %0d",
                     seen.trigger_level, seen.frame_done, seen.range_mm);
        end else begin
          want = due_results_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $write("ranger: mismatch (exp/act) trig %b/%b done %b/%b dist %0d/%0d ",
                     want.trigger_level, seen.trigger_level,
                     want.frame_done, seen.frame_done,
                     want.range_mm, seen.range_mm);
              $display("valid %b/%b status %0d/%0d frame %0d/%0d",
                       want.distance_valid, seen.distance_valid,
                       want.status, seen.status,
                       want.frame_number, seen.frame_number);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : run
    int unsigned seg;
    int unsigned lim;
    int unsigned sel;
    logic        echo;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.echo_level = 1'b0;
    res_if.ready     = 1'b0;
    plan_cfg         = CFG_RESET;
    live_cfg         = CFG_RESET;
    plan_ranger      = RANGER_IDLE;
    live_ranger      = RANGER_IDLE;

    // directed: disabled block at reset defaults stays quiet whatever the echo does
    add_ctl(ACT_MODE, 0, 0);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b1);
    add_tick(1'b0);
    // shortest timeouts, zero max distance, back-to-back measurements
    add_cfg(CFG_START_TIMEOUT, 1);
    add_cfg(CFG_PULSE_TIMEOUT, 1);
    add_cfg(CFG_MAX_DISTANCE, 0);
    add_cfg(CFG_SCAN_INTERVAL, 1);
    add_cfg(CFG_RUN_ENABLE, 1);
    // trigger low and high with echo toggling (ignored), then echo never comes
    for (int i = 0; i < 15; i++) add_tick(i[0]);
    add_tick(1'b0);
    add_tick(1'b0);

    // random segments: new settings, then echo waveforms shaped to the sequencer
    seg = 0;
    while (seg < 16) begin
      if (seg % 4 == 0) begin
        // pause until every owed result is back before the pacing changes
        add_ctl(ACT_DRAIN, 0, 0);
        case ((seg / 4) % 4)
          0:       add_ctl(ACT_MODE, 0, 0);
          1:       add_ctl(ACT_MODE, 56, 0);
          2:       add_ctl(ACT_MODE, 0, 56);
          default: add_ctl(ACT_MODE, 35, 35);
        endcase
      end

      add_cfg(CFG_RUN_ENABLE, ($urandom_range(9) == 0) ? 0 : 1);
      sel = $urandom_range(5);
      add_cfg(CFG_SCAN_INTERVAL, (sel == 0) ? 1 : (sel == 1) ? INTERVAL_MAX :
                                 $urandom_range(70, 2));
      sel = $urandom_range(5);
      add_cfg(CFG_MAX_DISTANCE, (sel == 0) ? 0 : (sel == 1) ? 16'hFFFF :
                                $urandom_range(12, 1));
      sel = $urandom_range(5);
      add_cfg(CFG_START_TIMEOUT, (sel == 0) ? 16'hFFFF : (sel == 1) ? 1 :
                                 $urandom_range(10, 1));
      sel = $urandom_range(5);
      add_cfg(CFG_PULSE_TIMEOUT, (sel == 0) ? 17'h1FFFF : (sel == 1) ? 1 :
                                 $urandom_range(60, 1));

      // result side stalls for a long stretch while ticks keep coming
      if (seg == 1) add_ctl(ACT_HOLDOFF, 0, 0);

      for (int t = 0; t < SEGMENT_TICKS; t++) begin
        if (plan_ranger.phase == PH_WAIT && !echo_planned) begin
          // waits and pulses reach just past their timeouts now and then
          lim          = (plan_cfg.echo_start_timeout_us > ECHO_WAIT_CAP) ?
                         ECHO_WAIT_CAP : plan_cfg.echo_start_timeout_us;
          echo_lows    = $urandom_range(lim + 2, 0);
          lim          = (plan_cfg.pulse_timeout_us > ECHO_PULSE_CAP) ?
                         ECHO_PULSE_CAP : plan_cfg.pulse_timeout_us;
          echo_highs   = $urandom_range(lim + 2, 1);
          echo_planned = 1'b1;
        end
        if (plan_ranger.phase != PH_WAIT && plan_ranger.phase != PH_PULSE) begin
          echo_planned = 1'b0;
          echo         = 1'($urandom_range(1));
        end else if (echo_lows != 0) begin
          echo = 1'b0;
          echo_lows--;
        end else if (echo_highs != 0) begin
          echo = 1'b1;
          echo_highs--;
        end else begin
          echo = 1'b0;
        end
        // stray samples break up some waits and pulses
        if ($urandom_range(99) < NOISE_PCT) echo = ~echo;
        add_tick(echo);
      end
      seg++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (echo_script_q.size() != 0 || in_if.valid || due_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += due_results_q.size();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
